### design/fccw_pkg.sv
`timescale 1ns / 1ps

package fccw_pkg;

    localparam int MAX_CHAIN = 1024;
    localparam int CNT_W     = $clog2(MAX_CHAIN + 1);
    localparam int IDX_W     = $clog2(MAX_CHAIN);
    localparam int LANES     = 8;
    localparam int LANE_W    = $clog2(LANES);
    localparam int ROWS      = MAX_CHAIN / LANES;
    localparam int ROW_W     = $clog2(ROWS);

    localparam int OFF_W     = 48;
    localparam int VAL_W     = 32;
    localparam int CL_W      = 28;
    localparam int ST_W      = 3;
    localparam int BPS_W     = 16;
    localparam int SPC_W     = 8;
    localparam int RS_W      = 16;
    localparam int NF_W      = 8;
    localparam int SPF_W     = 32;
    localparam int IMG_W     = 48;
    localparam int CB_W      = BPS_W + SPC_W;
    localparam int FB_W      = RS_W + BPS_W;
    localparam int P1_W      = NF_W + SPF_W;
    localparam int SUM_W     = P1_W + 1;
    localparam int DBRAW_W   = SUM_W + BPS_W;
    localparam int PROD_W    = CL_W + CB_W;
    localparam int DSUM_W    = PROD_W + 1;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 48;

    localparam logic [VAL_W-1:0] END_MARK   = 32'h0FFF_FFF8;
    localparam logic [VAL_W-1:0] ENTRY_MASK = 32'h0FFF_FFFF;
    localparam logic [OFF_W-1:0] OFF_MAX    = {OFF_W{1'b1}};

    localparam logic [BPS_W-1:0] RST_BPS = 16'd512;
    localparam logic [SPC_W-1:0] RST_SPC = 8'd8;
    localparam logic [RS_W-1:0]  RST_RS  = 16'd32;
    localparam logic [NF_W-1:0]  RST_NF  = 8'd2;
    localparam logic [SPF_W-1:0] RST_SPF = 32'd1024;
    localparam logic [IMG_W-1:0] RST_IMG = 48'd0;

    localparam logic REQ_START = 1'b0;
    localparam logic REQ_ENTRY = 1'b1;

    typedef enum logic [ST_W-1:0] {
        ST_CLUSTER    = 3'd0,
        ST_END        = 3'd1,
        ST_LOOP       = 3'd2,
        ST_FAT_RANGE  = 3'd3,
        ST_BAD_GEOM   = 3'd4,
        ST_FULL       = 3'd5,
        ST_UNEXPECTED = 3'd6
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BPS = 3'd0,
        CFG_SPC = 3'd1,
        CFG_RS  = 3'd2,
        CFG_NF  = 3'd3,
        CFG_SPF = 3'd4,
        CFG_IMG = 3'd5
    } t_cfg_idx;

    typedef enum logic [2:0] {
        D_IDLE,
        D_MUL1,
        D_SUM,
        D_MUL2,
        D_FIN
    } t_dstate;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_FAT,
        S_FCHK,
        S_MUL,
        S_DATA,
        S_OUT
    } t_state;

    typedef struct packed {
        logic [OFF_W-1:0] fat_base;
        logic [OFF_W-1:0] data_base;
        logic [CB_W-1:0]  cluster_bytes;
        logic [IMG_W-1:0] image_size;
        logic             ok;
    } t_geom;

    typedef struct packed {
        logic done;
        logic hit;
    } t_scan;

endpackage

### design/fat32_cluster_chain_walker_core.sv
`timescale 1ns / 1ps
// An idle entry, bad geometry or an end marker goes from idle straight to the output state and
// reaches the output register once it is free. With n clusters held, the loop check reads the
// chain store one row of 8 a cycle over ceil(n/8) rows (none when the chain is empty); a loop or a
// full store is then reported, and a new cluster passes the FAT, FCHK, MUL and DATA states. The next
// beat is taken the cycle after the result enters the output register, not while an item is in work.
// Reset and every register write re-derive the geometry in D_MUL1, D_SUM, D_MUL2, D_FIN; input stalls.
module fat32_cluster_chain_walker_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_req_type,
    input  logic [fccw_pkg::VAL_W-1:0]      i_value,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [fccw_pkg::ST_W-1:0]       o_status,
    output logic [fccw_pkg::CL_W-1:0]       o_cluster,
    output logic [fccw_pkg::OFF_W-1:0]      o_data_offset,
    output logic [fccw_pkg::OFF_W-1:0]      o_fat_address,
    output logic [fccw_pkg::CNT_W-1:0]      o_chain_length,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [fccw_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [fccw_pkg::CFG_W-1:0]      i_cfg_data
);
    import fccw_pkg::*;

    t_geom             geom;
    t_scan             scan;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_await, n_await;
    logic [CL_W-1:0]   r_cl, n_cl;
    t_status           r_st, n_st;
    logic [OFF_W-1:0]  r_fat, n_fat;
    logic [PROD_W-1:0] r_prod, n_prod;
    logic [OFF_W-1:0]  r_data, n_data;
    logic              r_out_valid, n_out_valid;
    logic [ST_W-1:0]   r_o_status, n_o_status;
    logic [CL_W-1:0]   r_o_cluster, n_o_cluster;
    logic [OFF_W-1:0]  r_o_data, n_o_data;
    logic [OFF_W-1:0]  r_o_fat, n_o_fat;
    logic [CNT_W-1:0]  r_o_len, n_o_len;

    logic              in_acc;
    logic              is_start;
    logic [VAL_W-1:0]  cval;
    logic [CNT_W-1:0]  cnt_eff;
    logic              scan_start;
    logic              st_we;
    logic [DSUM_W-1:0] dsum;
    logic [OFF_W:0]    fat_end;

    fccw_geom u_geom (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_geom      (geom)
    );

    fccw_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (st_we),
        .i_wr_idx  (r_count[IDX_W-1:0]),
        .i_wr_data (r_cl),
        .i_start   (scan_start),
        .i_key     (n_cl),
        .i_count   (cnt_eff),
        .o_scan    (scan)
    );

    assign o_in_stall = (r_state != S_IDLE) || !o_cfg_ready;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign is_start   = (i_req_type == REQ_START);
    assign cval       = is_start ? i_value : (i_value & ENTRY_MASK);
    assign cnt_eff    = is_start ? '0 : r_count;
    assign dsum       = DSUM_W'(geom.data_base) + DSUM_W'(r_prod);
    assign fat_end    = (OFF_W + 1)'(r_fat) + (OFF_W + 1)'(4);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_await     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_await     <= n_await;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cl        <= n_cl;
        r_st        <= n_st;
        r_fat       <= n_fat;
        r_prod      <= n_prod;
        r_data      <= n_data;
        r_o_status  <= n_o_status;
        r_o_cluster <= n_o_cluster;
        r_o_data    <= n_o_data;
        r_o_fat     <= n_o_fat;
        r_o_len     <= n_o_len;
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_await     = r_await;
        n_cl        = r_cl;
        n_st        = r_st;
        n_fat       = r_fat;
        n_prod      = r_prod;
        n_data      = r_data;
        n_out_valid = r_out_valid && i_out_stall;
        n_o_status  = r_o_status;
        n_o_cluster = r_o_cluster;
        n_o_data    = r_o_data;
        n_o_fat     = r_o_fat;
        n_o_len     = r_o_len;
        scan_start  = 1'b0;
        st_we       = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (is_start) begin
                        n_count = '0;
                        n_await = 1'b0;
                    end
                    if (!is_start && !r_await) begin
                        n_st    = ST_UNEXPECTED;
                        n_state = S_OUT;
                    end else if (!geom.ok) begin
                        n_await = 1'b0;
                        n_st    = ST_BAD_GEOM;
                        n_state = S_OUT;
                    end else begin
                        n_await = 1'b0;
                        if ((cval < VAL_W'(2)) || (cval >= END_MARK)) begin
                            n_st    = ST_END;
                            n_state = S_OUT;
                        end else begin
                            n_cl       = cval[CL_W-1:0];
                            scan_start = 1'b1;
                            n_state    = S_SCAN;
                        end
                    end
                end
            end
            S_SCAN: begin
                if (scan.done) begin
                    if (scan.hit) begin
                        n_st    = ST_LOOP;
                        n_state = S_OUT;
                    end else if (r_count >= CNT_W'(MAX_CHAIN)) begin
                        n_st    = ST_FULL;
                        n_state = S_OUT;
                    end else begin
                        n_state = S_FAT;
                    end
                end
            end
            S_FAT: begin
                n_fat   = geom.fat_base + OFF_W'({r_cl, 2'b00});
                n_state = S_FCHK;
            end
            S_FCHK: begin
                if (fat_end > (OFF_W + 1)'(geom.image_size)) begin
                    n_st    = ST_FAT_RANGE;
                    n_state = S_OUT;
                end else begin
                    st_we   = 1'b1;
                    n_count = r_count + CNT_W'(1);
                    n_await = 1'b1;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_prod  = PROD_W'(r_cl - CL_W'(2)) * PROD_W'(geom.cluster_bytes);
                n_state = S_DATA;
            end
            S_DATA: begin
                n_data  = (|dsum[DSUM_W-1:OFF_W]) ? OFF_MAX : dsum[OFF_W-1:0];
                n_st    = ST_CLUSTER;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_o_status  = r_st;
                    n_o_cluster = (r_st == ST_CLUSTER) ? r_cl : '0;
                    n_o_data    = (r_st == ST_CLUSTER) ? r_data : '0;
                    n_o_fat     = ((r_st == ST_CLUSTER) || (r_st == ST_FAT_RANGE)) ? r_fat : '0;
                    n_o_len     = r_count;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_o_status;
    assign o_cluster      = r_o_cluster;
    assign o_data_offset  = r_o_data;
    assign o_fat_address  = r_o_fat;
    assign o_chain_length = r_o_len;

endmodule

### design/fccw_geom.sv
`timescale 1ns / 1ps

module fccw_geom (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [fccw_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [fccw_pkg::CFG_W-1:0]        i_cfg_data,
    output fccw_pkg::t_geom                   o_geom
);
    import fccw_pkg::*;

    logic [BPS_W-1:0]   r_bps;
    logic [SPC_W-1:0]   r_spc;
    logic [RS_W-1:0]    r_rs;
    logic [NF_W-1:0]    r_nf;
    logic [SPF_W-1:0]   r_spf;
    logic [IMG_W-1:0]   r_img;

    t_dstate            r_dstate;
    t_dstate            n_dstate;

    logic [P1_W-1:0]    r_p1;
    logic [SUM_W-1:0]   r_sum;
    logic [DBRAW_W-1:0] r_dbraw;
    logic [OFF_W-1:0]   r_fb;
    logic [OFF_W-1:0]   r_db;
    logic [CB_W-1:0]    r_cb;
    logic               r_ok;

    logic               cfg_wr;
    logic [OFF_W-1:0]   db_sat;
    logic               regs_nonzero;

    assign cfg_wr = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bps    <= RST_BPS;
            r_spc    <= RST_SPC;
            r_rs     <= RST_RS;
            r_nf     <= RST_NF;
            r_spf    <= RST_SPF;
            r_img    <= RST_IMG;
            r_dstate <= D_MUL1;
        end else begin
            r_dstate <= n_dstate;
            if (cfg_wr) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_BPS: r_bps <= i_cfg_data[BPS_W-1:0];
                    CFG_SPC: r_spc <= i_cfg_data[SPC_W-1:0];
                    CFG_RS:  r_rs  <= i_cfg_data[RS_W-1:0];
                    CFG_NF:  r_nf  <= i_cfg_data[NF_W-1:0];
                    CFG_SPF: r_spf <= i_cfg_data[SPF_W-1:0];
                    CFG_IMG: r_img <= i_cfg_data[IMG_W-1:0];
                    default: r_img <= r_img;
                endcase
            end
        end
    end

    always_comb begin
        n_dstate    = r_dstate;
        o_cfg_ready = 1'b0;
        case (r_dstate)
            D_IDLE: begin
                o_cfg_ready = 1'b1;
                if (i_cfg_valid) begin
                    n_dstate = D_MUL1;
                end
            end
            D_MUL1:  n_dstate = D_SUM;
            D_SUM:   n_dstate = D_MUL2;
            D_MUL2:  n_dstate = D_FIN;
            D_FIN:   n_dstate = D_IDLE;
            default: n_dstate = D_IDLE;
        endcase
    end

    assign db_sat = (|r_dbraw[DBRAW_W-1:OFF_W]) ? OFF_MAX : r_dbraw[OFF_W-1:0];
    assign regs_nonzero = (r_bps != '0) && (r_spc != '0) && (r_rs != '0) &&
                          (r_nf != '0) && (r_spf != '0);

    always_ff @(posedge i_clk) begin
        case (r_dstate)
            D_MUL1: begin
                r_p1 <= P1_W'(r_nf) * P1_W'(r_spf);
                r_cb <= CB_W'(r_bps) * CB_W'(r_spc);
                r_fb <= OFF_W'(FB_W'(r_rs) * FB_W'(r_bps));
            end
            D_SUM: begin
                r_sum <= SUM_W'(r_p1) + SUM_W'(r_rs);
            end
            D_MUL2: begin
                r_dbraw <= DBRAW_W'(r_sum) * DBRAW_W'(r_bps);
            end
            D_FIN: begin
                r_db <= db_sat;
                r_ok <= regs_nonzero && (db_sat < r_img);
            end
            default: r_ok <= r_ok;
        endcase
    end

    assign o_geom.fat_base      = r_fb;
    assign o_geom.data_base     = r_db;
    assign o_geom.cluster_bytes = r_cb;
    assign o_geom.image_size    = r_img;
    assign o_geom.ok            = r_ok;

endmodule

### design/fccw_store.sv
`timescale 1ns / 1ps

module fccw_store (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_wr_en,
    input  logic [fccw_pkg::IDX_W-1:0]    i_wr_idx,
    input  logic [fccw_pkg::CL_W-1:0]     i_wr_data,
    input  logic                          i_start,
    input  logic [fccw_pkg::CL_W-1:0]     i_key,
    input  logic [fccw_pkg::CNT_W-1:0]    i_count,
    output fccw_pkg::t_scan               o_scan
);
    import fccw_pkg::*;

    logic [CL_W-1:0]  r_mem [ROWS][LANES];
    logic [CL_W-1:0]  r_rdata [LANES];

    logic             r_scan_on;
    logic             r_cmp_v;
    logic             r_done;
    logic             r_hit;
    logic [ROW_W-1:0] r_rd_row;
    logic [ROW_W-1:0] r_cmp_row;
    logic [ROW_W-1:0] r_last_row;
    logic [CL_W-1:0]  r_key;
    logic [CNT_W-1:0] r_cnt;

    logic [CNT_W-1:0] cnt_m1;
    logic             lane_hit;

    assign cnt_m1 = i_count - CNT_W'(1);

    always_comb begin
        lane_hit = 1'b0;
        for (int l = 0; l < LANES; l++) begin
            if ((CNT_W'({r_cmp_row, LANE_W'(l)}) < r_cnt) && (r_rdata[l] == r_key)) begin
                lane_hit = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_idx[IDX_W-1:LANE_W]][i_wr_idx[LANE_W-1:0]] <= i_wr_data;
        end
        r_rdata <= r_mem[r_rd_row];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_on <= 1'b0;
            r_cmp_v   <= 1'b0;
            r_done    <= 1'b0;
            r_hit     <= 1'b0;
            r_rd_row  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_hit     <= 1'b0;
                r_rd_row  <= '0;
                r_cmp_v   <= 1'b0;
                r_scan_on <= (i_count != '0);
                r_done    <= (i_count == '0);
            end else begin
                r_cmp_v <= r_scan_on;
                if (r_scan_on) begin
                    if (r_rd_row == r_last_row) begin
                        r_scan_on <= 1'b0;
                    end else begin
                        r_rd_row <= r_rd_row + ROW_W'(1);
                    end
                end
                if (r_cmp_v) begin
                    if (lane_hit) begin
                        r_hit <= 1'b1;
                    end
                    if (r_cmp_row == r_last_row) begin
                        r_done <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmp_row <= r_rd_row;
        if (i_start) begin
            r_key      <= i_key;
            r_cnt      <= i_count;
            r_last_row <= cnt_m1[LANE_W+ROW_W-1:LANE_W];
        end
    end

    assign o_scan.done = r_done;
    assign o_scan.hit  = r_hit;

endmodule
